[rtl/spd_pkg.sv]
// ---------------------------------------------------------------------------
// spd_pkg: shared types and codes of the slotted page row directory
// Word formats, entry layout, operation and status codes, cell control.
// ---------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

    localparam logic [2:0] K_ALLOC   = 3'd0;
    localparam logic [2:0] K_RELEASE = 3'd1;
    localparam logic [2:0] K_LOOKUP  = 3'd2;
    localparam logic [2:0] K_SETNEXT = 3'd3;
    localparam logic [2:0] K_CLEAR   = 3'd4;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NOTFOUND = 2'd1;
    localparam logic [1:0] STS_NOSPACE  = 2'd2;
    localparam logic [1:0] STS_FULL     = 2'd3;

    localparam int ROW_SLOTS = 256;
    localparam int GRP       = 16;    // cells per first-level readout group

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  row_id;
        logic [16:0] length;
        logic [31:0] link_page;
        logic [7:0]  link_row;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  result_row;
        logic [16:0] row_offset;
        logic [16:0] row_length;
        logic [31:0] next_page;
        logic [7:0]  next_row;
        logic [16:0] free_bytes;
        logic [16:0] move_source;
        logic [16:0] move_dest;
        logic [16:0] move_length;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  id;
        logic [16:0] offset;
        logic [16:0] size;
        logic [31:0] page;
        logic [7:0]  row;
    } t_entry;

    typedef enum logic [1:0] {
        CO_HOLD = 2'd0,
        CO_INS  = 2'd1,
        CO_DEL  = 2'd2,
        CO_LINK = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [7:0]  key;
        logic [8:0]  pos;
        t_entry      new_ent;
        logic [16:0] toff;
        logic [16:0] tsz;
        logic [8:0]  rc;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/spd_cell.sv]
// ---------------------------------------------------------------------------
// spd_cell: one directory slot
// Holds one entry; shifts from its neighbors on insert and remove.
// ---------------------------------------------------------------------------
`default_nettype none

module spd_cell #(
    parameter int IDX = 0
) (
    input  wire               i_clk,
    input  spd_pkg::t_cell_ctl i_ctl,
    input  spd_pkg::t_entry   i_left,
    input  spd_pkg::t_entry   i_right,
    input  wire               i_right_eq,
    output spd_pkg::t_entry   o_entry,
    output logic              o_eq,
    output logic              o_sel,
    output logic              o_bnd
);
    import spd_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    t_entry w_src;
    logic   w_valid;

    assign w_valid = 9'(IDX) < i_ctl.rc;
    assign o_entry = r_ent;
    assign o_eq    = w_valid && (r_ent.id == 8'(IDX));
    assign o_sel   = w_valid && (r_ent.id == i_ctl.key);
    assign o_bnd   = o_eq && !i_right_eq;   // last slot of the dense id run

    always_comb begin
        n_ent = r_ent;
        w_src = r_ent;
        case (i_ctl.op)
            CO_INS: begin
                if (9'(IDX) == i_ctl.pos) begin
                    n_ent = i_ctl.new_ent;
                end else if (9'(IDX) > i_ctl.pos) begin
                    n_ent = i_left;
                end
            end
            CO_DEL: begin
                if (w_valid && (r_ent.id >= i_ctl.key)) begin
                    w_src = i_right;
                end
                n_ent = w_src;
                if (w_src.offset < i_ctl.toff) begin
                    n_ent.offset = w_src.offset + i_ctl.tsz;
                end
            end
            CO_LINK: begin
                if (o_sel) begin
                    n_ent.page = i_ctl.new_ent.page;
                    n_ent.row  = i_ctl.new_ent.row;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

`default_nettype wire

[rtl/slotted_page_row_directory.sv]
// Flow: an accepted word passes the readout group and readout sum steps,
//   then the execute step writes the result register.
// Words: one at a time; each passes the two-level readout over the slot
//   chain and the single execute step, and a new word waits for the output.
// Reset: synchronous active low; row count 0, lowest data offset and page
//   size 4096. Slot contents are not reset.
// ---------------------------------------------------------------------------
// slotted_page_row_directory: row directory of one slotted page
// Sorted chain of slot cells with parallel match, shift and offset fixup.
// ---------------------------------------------------------------------------
`default_nettype none

module slotted_page_row_directory #(
    parameter int MAX_ROWS     = 256,
    parameter int HEADER_BYTES = 32,
    parameter int ENTRY_BYTES  = 20
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  spd_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output spd_pkg::t_out_word  o_out_word,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [16:0]          i_cfg_data
);
    import spd_pkg::*;

    localparam int CAP = (MAX_ROWS < ROW_SLOTS) ? MAX_ROWS : ROW_SLOTS;
    localparam int NG  = (CAP + GRP - 1) / GRP;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GRP  = 5'b00010,
        S_SUM  = 5'b00100,
        S_EXE  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    t_in_word    r_in;
    t_out_word   r_out, n_out;
    logic [8:0]  r_rc, n_rc;
    logic [16:0] r_low, n_low;
    logic [16:0] r_page_bytes;

    // readout tree registers
    t_entry      r_g_ent [NG];
    logic [NG-1:0] r_g_hit;
    logic [8:0]  r_g_fid [NG];
    t_entry      r_hit_ent;
    logic        r_found;
    logic [8:0]  r_fid;

    t_entry      w_g_ent [NG];
    logic [NG-1:0] w_g_hit;
    logic [8:0]  w_g_fid [NG];
    t_entry      w_s_ent;
    logic        w_s_hit;
    logic [8:0]  w_s_fid;

    // slot chain
    t_cell_ctl   w_ctl;
    t_entry      w_ent [CAP];
    logic [CAP-1:0] w_eq, w_sel, w_bnd;

    logic [16:0] w_free_now;
    logic [16:0] w_new_off;

    function automatic logic [16:0] free_of(input logic [16:0] low, input logic [8:0] rc);
        logic [19:0] used;
        logic [19:0] diff;
        used = 20'(HEADER_BYTES) + 20'(({11'b0, rc} + 20'd1) * 20'(ENTRY_BYTES));
        diff = {3'b0, low} - used;
        return diff[19] ? 17'd0 : diff[16:0];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_free_now = free_of(r_low, r_rc);
    assign w_new_off  = r_low - r_in.length;

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_cell
            spd_cell #(.IDX(gi)) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_left     ((gi == 0) ? t_entry'('0) : w_ent[(gi == 0) ? 0 : gi - 1]),
                .i_right    ((gi == CAP - 1) ? t_entry'('0)
                                             : w_ent[(gi == CAP - 1) ? gi : gi + 1]),
                .i_right_eq ((gi == CAP - 1) ? 1'b0
                                             : w_eq[(gi == CAP - 1) ? gi : gi + 1]),
                .o_entry    (w_ent[gi]),
                .o_eq       (w_eq[gi]),
                .o_sel      (w_sel[gi]),
                .o_bnd      (w_bnd[gi])
            );
        end
    endgenerate

    // first readout level: one-hot OR within each group of slots
    always_comb begin
        int c;
        for (int g = 0; g < NG; g++) begin
            w_g_ent[g] = '0;
            w_g_hit[g] = 1'b0;
            w_g_fid[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                c = g * GRP + k;
                if (c < CAP) begin
                    if (w_sel[c]) begin
                        w_g_ent[g] = w_g_ent[g] | w_ent[c];
                        w_g_hit[g] = 1'b1;
                    end
                    if (w_bnd[c]) begin
                        w_g_fid[g] = w_g_fid[g] | 9'(c + 1);
                    end
                end
            end
        end
    end

    // second readout level
    always_comb begin
        w_s_ent = '0;
        w_s_fid = '0;
        w_s_hit = |r_g_hit;
        for (int g = 0; g < NG; g++) begin
            w_s_ent = w_s_ent | r_g_ent[g];
            w_s_fid = w_s_fid | r_g_fid[g];
        end
    end

    // state sequence and execute step: decide, drive slot chain, build result
    always_comb begin
        n_state = r_state;
        n_rc    = r_rc;
        n_low   = r_low;
        n_out   = r_out;
        w_ctl   = '0;
        w_ctl.op      = CO_HOLD;
        w_ctl.key     = r_in.row_id;
        w_ctl.pos     = r_fid;
        w_ctl.rc      = r_rc;
        w_ctl.toff    = r_hit_ent.offset;
        w_ctl.tsz     = r_hit_ent.size;
        w_ctl.new_ent.id     = r_fid[7:0];
        w_ctl.new_ent.offset = w_new_off;
        w_ctl.new_ent.size   = r_in.length;
        w_ctl.new_ent.page   = (r_in.kind == K_SETNEXT) ? r_in.link_page : 32'd0;
        w_ctl.new_ent.row    = (r_in.kind == K_SETNEXT) ? r_in.link_row : 8'd0;

        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_GRP;
            S_GRP:  n_state = S_SUM;
            S_SUM:  n_state = S_EXE;
            S_EXE: begin
                n_state = S_OUT;
                n_out   = '0;
                case (r_in.kind)
                    K_ALLOC: begin
                        if (r_rc >= 9'(CAP)) begin
                            n_out.status = STS_FULL;
                        end else if (r_in.length > w_free_now) begin
                            n_out.status = STS_NOSPACE;
                        end else begin
                            w_ctl.op = CO_INS;
                            n_rc     = r_rc + 9'd1;
                            n_low    = w_new_off;
                            n_out.result_row = r_fid[7:0];
                            n_out.row_offset = w_new_off;
                            n_out.row_length = r_in.length;
                        end
                    end
                    K_RELEASE: begin
                        if (!r_found) begin
                            n_out.status = STS_NOTFOUND;
                        end else begin
                            w_ctl.op = CO_DEL;
                            n_rc     = r_rc - 9'd1;
                            n_low    = r_low + r_hit_ent.size;
                            n_out.result_row = r_hit_ent.id;
                            n_out.row_offset = r_hit_ent.offset;
                            n_out.row_length = r_hit_ent.size;
                            n_out.next_page  = r_hit_ent.page;
                            n_out.next_row   = r_hit_ent.row;
                            if (r_hit_ent.offset > r_low) begin
                                n_out.move_source = r_low;
                                n_out.move_dest   = r_low + r_hit_ent.size;
                                n_out.move_length = r_hit_ent.offset - r_low;
                            end
                        end
                    end
                    K_LOOKUP, K_SETNEXT: begin
                        if (!r_found) begin
                            n_out.status = STS_NOTFOUND;
                        end else begin
                            n_out.result_row = r_hit_ent.id;
                            n_out.row_offset = r_hit_ent.offset;
                            n_out.row_length = r_hit_ent.size;
                            n_out.next_page  = r_hit_ent.page;
                            n_out.next_row   = r_hit_ent.row;
                            if (r_in.kind == K_SETNEXT) begin
                                w_ctl.op        = CO_LINK;
                                n_out.next_page = r_in.link_page;
                                n_out.next_row  = r_in.link_row;
                            end
                        end
                    end
                    K_CLEAR: begin
                        n_rc  = '0;
                        n_low = r_page_bytes;
                    end
                    default: ;
                endcase
                n_out.free_bytes = free_of(n_low, n_rc);
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rc         <= '0;
            r_low        <= 17'd4096;
            r_page_bytes <= 17'd4096;
        end else begin
            r_state <= n_state;
            r_rc    <= n_rc;
            r_low   <= n_low;
            if (i_cfg_valid) begin
                r_page_bytes <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (r_state == S_GRP) begin
            r_g_ent <= w_g_ent;
            r_g_hit <= w_g_hit;
            r_g_fid <= w_g_fid;
        end
        if (r_state == S_SUM) begin
            r_hit_ent <= w_s_ent;
            r_found   <= w_s_hit;
            r_fid     <= w_s_fid;
        end
        r_out <= n_out;
    end

endmodule

`default_nettype wire

[rtl/spd_checker.sv]
// ---------------------------------------------------------------------------
// spd_checker: port level checks of the row directory
// Busy after accept, one word at a time, stable stalled results, clean failed results.
// ---------------------------------------------------------------------------
`default_nettype none

module spd_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input spd_pkg::t_out_word  o_out_word,
    input wire                 o_out_valid,
    input wire                 i_out_ready
);
    import spd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again before the word finished");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != STS_OK |->
            o_out_word.move_length == 17'd0 && o_out_word.row_offset == 17'd0
            && o_out_word.result_row == 8'd0)
        else $error("failed operation reports entry or move data");

endmodule

bind slotted_page_row_directory spd_checker u_spd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_word  (o_out_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);

`default_nettype wire
